// ===== rtl/tllh_pkg.sv =====
// Shared types, constants and helper functions for the thread latency histogram.
`timescale 1ns / 1ps
package tllh_pkg;

    localparam int TS_W     = 64;
    localparam int BUCKET_W = 6;
    localparam int NUM_BUCKETS = 64;
    // Widest id is 65535 * 2047 + 1023, which fits in 27 bits.
    localparam int ID_W     = 27;

    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_EXIT  = 1'b1;

    localparam logic [1:0] STAT_START    = 2'd0;
    localparam logic [1:0] STAT_MEASURED = 2'd1;
    localparam logic [1:0] STAT_NO_START = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ID,
        S_READ,
        S_CALC,
        S_LOG,
        S_HIST,
        S_DONE
    } t_state;

    // Index of the highest set bit; zero for an input of zero or one.
    function automatic logic [BUCKET_W-1:0] floor_log2(input logic [TS_W-1:0] v);
        logic [BUCKET_W-1:0] r;
        r = '0;
        for (int i = 1; i < TS_W; i++) begin
            if (v[i]) begin
                r = BUCKET_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/thread_latency_log2_histogram.sv =====
// Top level: per-thread start table and log2 latency histogram with running statistics.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   operation, block/thread ids, timestamp
//  out      output     o_out_valid / i_out_ready status, duration, bucket, statistics
//
// An item passes from acceptance to its result register through id multiply,
// table read, duration subtract, bucket select plus histogram read and histogram
// write-back; enter and out-of-range items finish after the table access.
// The next item is accepted while the previous result waits to be taken.
// After reset the start table is swept clear, one entry a cycle, before the
// first item is accepted. A stalled output holds the block in its final state
// until the pending result is taken.
`timescale 1ns / 1ps
module thread_latency_log2_histogram #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_block_index,
    input  logic [10:0] i_block_size,
    input  logic [9:0]  i_thread_index,
    input  logic [63:0] i_timestamp,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_duration,
    output logic [5:0]  o_bucket,
    output logic [63:0] o_bucket_count,
    output logic [63:0] o_min_duration_out,
    output logic [63:0] o_max_duration_out,
    output logic [63:0] o_total_duration_out,
    output logic [63:0] o_sample_count_out
);

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int TS_W = tllh_pkg::TS_W;
    localparam int BW = tllh_pkg::BUCKET_W;

    tllh_pkg::t_state r_state, n_state;

    logic [TAW-1:0]          r_clr;
    logic                    r_op;
    logic [15:0]             r_bidx;
    logic [10:0]             r_bsize;
    logic [9:0]              r_tidx;
    logic [TS_W-1:0]         r_ts;
    logic [tllh_pkg::ID_W-1:0] r_id;
    logic                    r_oor;
    logic [TS_W-1:0]         r_dur;
    logic [BW-1:0]           r_bucket;
    logic [TS_W-1:0]         r_bcount;
    logic [1:0]              r_stat;
    logic [tllh_pkg::NUM_BUCKETS-1:0] r_hvalid;
    logic [TS_W-1:0]         r_min, r_max, r_sum, r_count;

    logic                    r_out_valid;
    logic [1:0]              r_o_status;
    logic [TS_W-1:0]         r_o_dur, r_o_bcount, r_o_min, r_o_max, r_o_sum, r_o_count;
    logic [BW-1:0]           r_o_bucket;

    logic                    tbl_we;
    logic [TAW-1:0]          tbl_waddr, tbl_idx;
    logic [TS_W:0]           tbl_wdata, tbl_rdata;
    logic                    hist_we;
    logic [BW-1:0]           hist_raddr;
    logic [TS_W-1:0]         hist_rdata, hist_cur, hist_new;
    logic                    in_acc, out_load;
    logic [tllh_pkg::ID_W-1:0] n_id;

    assign tbl_idx    = r_id[TAW-1:0];
    assign hist_raddr = tllh_pkg::floor_log2(r_dur);
    assign hist_cur   = r_hvalid[r_bucket] ? hist_rdata : '0;
    assign hist_new   = hist_cur + TS_W'(1);
    assign n_id       = tllh_pkg::ID_W'(r_bidx) * tllh_pkg::ID_W'(r_bsize)
                      + tllh_pkg::ID_W'(r_tidx);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == tllh_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tllh_pkg::S_CLEAR: begin
                if (r_clr == TAW'(TABLE_DEPTH - 1)) begin
                    n_state = tllh_pkg::S_IDLE;
                end
            end
            tllh_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = tllh_pkg::S_ID;
                end
            end
            tllh_pkg::S_ID:   n_state = tllh_pkg::S_READ;
            tllh_pkg::S_READ: begin
                if (r_oor || r_op == tllh_pkg::OP_ENTER) begin
                    n_state = tllh_pkg::S_DONE;
                end else begin
                    n_state = tllh_pkg::S_CALC;
                end
            end
            tllh_pkg::S_CALC: begin
                if (tbl_rdata[TS_W]) begin
                    n_state = tllh_pkg::S_LOG;
                end else begin
                    n_state = tllh_pkg::S_DONE;
                end
            end
            tllh_pkg::S_LOG:  n_state = tllh_pkg::S_HIST;
            tllh_pkg::S_HIST: n_state = tllh_pkg::S_DONE;
            tllh_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = tllh_pkg::S_IDLE;
                end
            end
            default: n_state = tllh_pkg::S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        o_in_ready = 1'b0;
        tbl_we     = 1'b0;
        tbl_waddr  = tbl_idx;
        tbl_wdata  = {1'b0, tbl_rdata[TS_W-1:0]};
        hist_we    = 1'b0;
        case (r_state)
            tllh_pkg::S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr;
                tbl_wdata = '0;
            end
            tllh_pkg::S_IDLE: o_in_ready = 1'b1;
            tllh_pkg::S_READ: begin
                if (!r_oor && r_op == tllh_pkg::OP_ENTER) begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {1'b1, r_ts};
                end
            end
            tllh_pkg::S_CALC: tbl_we = tbl_rdata[TS_W];
            tllh_pkg::S_HIST: hist_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tllh_pkg::S_CLEAR;
            r_clr       <= '0;
            r_hvalid    <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tllh_pkg::S_CLEAR) begin
                r_clr <= r_clr + TAW'(1);
            end
            if (r_state == tllh_pkg::S_HIST) begin
                r_hvalid[r_bucket] <= 1'b1;
                r_sum   <= r_sum + r_dur;
                r_count <= r_count + TS_W'(1);
                if (r_dur < r_min) begin
                    r_min <= r_dur;
                end
                if (r_dur > r_max) begin
                    r_max <= r_dur;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_operation;
            r_bidx  <= i_block_index;
            r_bsize <= i_block_size;
            r_tidx  <= i_thread_index;
            r_ts    <= i_timestamp;
        end
        case (r_state)
            tllh_pkg::S_ID: begin
                r_id  <= n_id;
                r_oor <= n_id >= tllh_pkg::ID_W'(TABLE_DEPTH);
            end
            tllh_pkg::S_READ: begin
                r_dur    <= '0;
                r_bucket <= '0;
                r_bcount <= '0;
                if (r_oor) begin
                    r_stat <= tllh_pkg::STAT_RANGE;
                end else begin
                    r_stat <= tllh_pkg::STAT_START;
                end
            end
            tllh_pkg::S_CALC: begin
                if (tbl_rdata[TS_W]) begin
                    r_dur  <= r_ts - tbl_rdata[TS_W-1:0];
                    r_stat <= tllh_pkg::STAT_MEASURED;
                end else begin
                    r_stat <= tllh_pkg::STAT_NO_START;
                end
            end
            tllh_pkg::S_LOG:  r_bucket <= hist_raddr;
            tllh_pkg::S_HIST: r_bcount <= hist_new;
            default: ;
        endcase
        if (out_load) begin
            r_o_status <= r_stat;
            r_o_dur    <= r_dur;
            r_o_bucket <= r_bucket;
            r_o_bcount <= r_bcount;
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_sum    <= r_sum;
            r_o_count  <= r_count;
        end
    end

    // Start table: valid bit above the stored timestamp.
    tllh_ram #(
        .WIDTH (TS_W + 1),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_idx),
        .o_rdata (tbl_rdata)
    );

    tllh_ram #(
        .WIDTH (TS_W),
        .DEPTH (tllh_pkg::NUM_BUCKETS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_bucket),
        .i_wdata (hist_new),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_o_status;
    assign o_duration           = r_o_dur;
    assign o_bucket             = r_o_bucket;
    assign o_bucket_count       = r_o_bcount;
    assign o_min_duration_out   = r_o_min;
    assign o_max_duration_out   = r_o_max;
    assign o_total_duration_out = r_o_sum;
    assign o_sample_count_out   = r_o_count;

`ifndef ASSERT_OFF
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tllh_pkg::S_HIST |=> r_count == $past(r_count) + TS_W'(1))
        else $error("sample count did not advance on a measured item");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hvalid != '0 |-> r_min <= r_max)
        else $error("minimum duration exceeds maximum");

    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tllh_pkg::S_CLEAR |-> !o_in_ready && !tbl_rdata[TS_W] || !o_in_ready)
        else $error("item accepted during table clear");

    a_hist_after_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> $past(r_state) == tllh_pkg::S_LOG && r_stat == tllh_pkg::STAT_MEASURED)
        else $error("histogram written outside a measured item");
`endif

endmodule

// ===== rtl/tllh_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module tllh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the thread latency log2 histogram block.
`timescale 1ns / 1ps
module tb;

    localparam int ID_LIMIT    = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] duration;
        logic [5:0]  bucket;
        logic [63:0] bucket_count;
        logic [63:0] min_dur;
        logic [63:0] max_dur;
        logic [63:0] total_dur;
        logic [63:0] samples;
    } t_latency_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [15:0] i_block_index;
    logic [10:0] i_block_size;
    logic [9:0]  i_thread_index;
    logic [63:0] i_timestamp;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [63:0] o_duration;
    logic [5:0]  o_bucket;
    logic [63:0] o_bucket_count;
    logic [63:0] o_min_duration_out;
    logic [63:0] o_max_duration_out;
    logic [63:0] o_total_duration_out;
    logic [63:0] o_sample_count_out;

    // Predicted state of the block.
    logic [63:0] start_time [ID_LIMIT];
    bit          start_ok [ID_LIMIT];
    bit   [63:0] bucket_tally [64];
    logic [63:0] run_min = '1;
    logic [63:0] run_max = '0;
    logic [63:0] run_total = '0;
    logic [63:0] run_samples = '0;

    t_latency_report awaited_reports [$];
    t_latency_report awaited_head;
    int unsigned     live_ids [$];

    int error_count = 0;
    int events_sent = 0;
    int reports_checked = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int cycle_count = 0;
    int ready_hold_cycles = 0;
    bit no_idle = 1'b0;

    thread_latency_log2_histogram #(
        .TABLE_DEPTH(ID_LIMIT)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_block_index       (i_block_index),
        .i_block_size        (i_block_size),
        .i_thread_index      (i_thread_index),
        .i_timestamp         (i_timestamp),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_duration          (o_duration),
        .o_bucket            (o_bucket),
        .o_bucket_count      (o_bucket_count),
        .o_min_duration_out  (o_min_duration_out),
        .o_max_duration_out  (o_max_duration_out),
        .o_total_duration_out(o_total_duration_out),
        .o_sample_count_out  (o_sample_count_out)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: timeout after %0d cycles, %0d reports still awaited",
                 CYCLE_LIMIT, awaited_reports.size());
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
            input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d: %s is %h, should be %h",
                                   reports_checked, name, got, want));
        end
    endtask

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // Duration whose highest set bit is picked uniformly, so every bucket is reached.
    function automatic logic [63:0] random_duration();
        int unsigned bits;
        logic [63:0] d;
        bits = $urandom_range(64);
        if (bits == 0) begin
            return 64'd0;
        end
        d = rand_word64() >> (64 - bits);
        return d | (64'd1 << (bits - 1));
    endfunction

    function automatic logic [5:0] bucket_of(input logic [63:0] d);
        logic [5:0] n;
        n = '0;
        while (d > 64'd1) begin
            d = d >> 1;
            n++;
        end
        return n;
    endfunction

    task automatic predict_latency_report(input logic op, input logic [15:0] bidx,
            input logic [10:0] bsize, input logic [9:0] tidx, input logic [63:0] ts);
        t_latency_report r;
        logic [63:0] id;
        r = '0;
        id = 64'(bidx) * 64'(bsize) + 64'(tidx);
        if (id >= ID_LIMIT) begin
            r.status = tllh_pkg::STAT_RANGE;
        end else if (op == tllh_pkg::OP_ENTER) begin
            start_time[int'(id)] = ts;
            start_ok[int'(id)] = 1'b1;
            r.status = tllh_pkg::STAT_START;
        end else if (!start_ok[int'(id)]) begin
            r.status = tllh_pkg::STAT_NO_START;
        end else begin
            start_ok[int'(id)] = 1'b0;
            r.duration = ts - start_time[int'(id)];
            r.bucket = bucket_of(r.duration);
            bucket_tally[r.bucket] = bucket_tally[r.bucket] + 64'd1;
            r.bucket_count = bucket_tally[r.bucket];
            run_total = run_total + r.duration;
            run_samples = run_samples + 64'd1;
            if (r.duration < run_min) begin
                run_min = r.duration;
            end
            if (r.duration > run_max) begin
                run_max = r.duration;
            end
            r.status = tllh_pkg::STAT_MEASURED;
        end
        r.min_dur = run_min;
        r.max_dur = run_max;
        r.total_dur = run_total;
        r.samples = run_samples;
        awaited_reports.push_back(r);
    endtask

    // Offers one item and returns at the edge where it is taken. Valid stays high
    // afterwards unless the next call opens a gap first.
    task automatic send_event(input logic op, input logic [15:0] bidx,
            input logic [10:0] bsize, input logic [9:0] tidx, input logic [63:0] ts);
        if (!no_idle && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_block_index  <= bidx;
        i_block_size   <= bsize;
        i_thread_index <= tidx;
        i_timestamp    <= ts;
        do @(posedge i_clk); while (!o_in_ready);
        predict_latency_report(op, bidx, bsize, tidx, ts);
        events_sent++;
    endtask

    // Names a thread id through a random block shape.
    task automatic send_to_id(input logic op, input int unsigned id, input logic [63:0] ts);
        logic [10:0] bsize;
        bsize = 11'($urandom_range(1, 1024));
        send_event(op, 16'(id / bsize), bsize, 10'(id % bsize), ts);
    endtask

    task automatic send_stray();
        logic [15:0] bidx;
        bidx = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8));
        send_event(1'($urandom), bidx, 11'($urandom_range(1, 1024)),
                   10'($urandom), rand_word64());
    endtask

    // One step of enter/exit traffic: mostly matched pairs, some repeats and strays.
    task automatic paired_step();
        int unsigned roll;
        int unsigned id;
        int unsigned idx;
        roll = $urandom_range(99);
        if (roll < 8) begin
            send_stray();
        end else if (roll < 13 && live_ids.size() != 0) begin
            id = live_ids[$urandom_range(live_ids.size() - 1)];
            send_to_id(tllh_pkg::OP_ENTER, id, rand_word64());
            live_ids.push_back(id);
        end else if (live_ids.size() == 0 || (live_ids.size() < 32 && roll < 55)) begin
            id = $urandom_range(ID_LIMIT - 1);
            send_to_id(tllh_pkg::OP_ENTER, id, rand_word64());
            live_ids.push_back(id);
        end else begin
            idx = $urandom_range(live_ids.size() - 1);
            id = live_ids[idx];
            live_ids.delete(idx);
            send_to_id(tllh_pkg::OP_EXIT, id, start_time[id] + random_duration());
        end
    endtask

    task automatic test_directed_cases();
        // Zero and one durations both land in bucket zero.
        send_event(tllh_pkg::OP_ENTER, 16'd0, 11'd1, 10'd0, 64'd0);
        send_event(tllh_pkg::OP_EXIT, 16'd0, 11'd1, 10'd0, 64'd0);
        send_event(tllh_pkg::OP_ENTER, 16'd0, 11'd1024, 10'd0, 64'd100);
        send_event(tllh_pkg::OP_EXIT, 16'd0, 11'd1, 10'd0, 64'd101);
        // Highest id in range, with a timestamp that wraps past zero.
        send_event(tllh_pkg::OP_ENTER, 16'd3, 11'd1024, 10'd1023, '1);
        send_event(tllh_pkg::OP_EXIT, 16'd4095, 11'd1, 10'd0, 64'd1);
        send_event(tllh_pkg::OP_ENTER, 16'd4095, 11'd1, 10'd0, 64'd0);
        send_event(tllh_pkg::OP_EXIT, 16'd3, 11'd1024, 10'd1023, '1);
        // Exits with no recorded start.
        send_event(tllh_pkg::OP_EXIT, 16'd4095, 11'd1, 10'd0, 64'd7);
        send_event(tllh_pkg::OP_EXIT, 16'd17, 11'd1, 10'd0, 64'd9);
        // A repeated enter replaces the start time.
        send_event(tllh_pkg::OP_ENTER, 16'd5, 11'd1, 10'd0, 64'd1000);
        send_event(tllh_pkg::OP_ENTER, 16'd1, 11'd4, 10'd1, 64'd2000);
        send_event(tllh_pkg::OP_EXIT, 16'd0, 11'd8, 10'd5, 64'd2000 + (64'd1 << 40));
        // Ids just past the table and the widest id that a block size of 1024 gives.
        send_event(tllh_pkg::OP_ENTER, 16'd4, 11'd1024, 10'd0, 64'd55);
        send_event(tllh_pkg::OP_EXIT, 16'd4096, 11'd1, 10'd0, 64'd56);
        send_event(tllh_pkg::OP_ENTER, 16'hFFFF, 11'd1024, 10'd1023, rand_word64());
        send_event(tllh_pkg::OP_EXIT, 16'hFFFF, 11'd1024, 10'd1023, rand_word64());
        send_event(tllh_pkg::OP_ENTER, 16'hFFFF, 11'd1, 10'd0, rand_word64());
        send_event(tllh_pkg::OP_ENTER, 16'd0, 11'd1, 10'd1023, 64'h8000_0000_0000_0000);
        send_event(tllh_pkg::OP_EXIT, 16'd1, 11'd1000, 10'd23, 64'h8000_0000_0000_0003);
        send_event(tllh_pkg::OP_EXIT, 16'd0, 11'd1024, 10'd1023, 64'd3);
        // A second all-ones duration ties the maximum and counts twice in the top bucket.
        send_event(tllh_pkg::OP_ENTER, 16'd1, 11'd1, 10'd0, 64'd5);
        send_event(tllh_pkg::OP_EXIT, 16'd0, 11'd2, 10'd1, 64'd4);
    endtask

    task automatic test_paired_sessions(input int count);
        repeat (count) paired_step();
    endtask

    task automatic test_stray_events(input int count);
        repeat (count) send_stray();
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_output_hold(input int count);
        ready_hold_cycles = 300;
        repeat (count) paired_step();
    endtask

    task automatic test_steady_stream(input int count);
        no_idle = 1'b1;
        repeat (count) paired_step();
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reports.size() == 0) begin
                report_error("result arrived with no item awaiting one");
            end else begin
                awaited_head = awaited_reports.pop_front();
                check_field("status", 64'(o_status), 64'(awaited_head.status));
                check_field("duration", o_duration, awaited_head.duration);
                check_field("bucket", 64'(o_bucket), 64'(awaited_head.bucket));
                check_field("bucket_count", o_bucket_count, awaited_head.bucket_count);
                check_field("min_duration", o_min_duration_out, awaited_head.min_dur);
                check_field("max_duration", o_max_duration_out, awaited_head.max_dur);
                check_field("total_duration", o_total_duration_out, awaited_head.total_dur);
                check_field("sample_count", o_sample_count_out, awaited_head.samples);
                status_tally[awaited_head.status]++;
            end
            reports_checked++;
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                ready_hold_cycles--;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin
        int buckets_used;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = tllh_pkg::OP_ENTER;
        i_block_index  = '0;
        i_block_size   = 11'd1;
        i_thread_index = '0;
        i_timestamp    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_paired_sessions(650);
        test_stray_events(150);
        test_output_hold(40);
        test_steady_stream(60);

        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        buckets_used = 0;
        for (int b = 0; b < 64; b++) begin
            if (bucket_tally[b] != 0) begin
                buckets_used++;
            end
        end
        $display("tb: %0d items sent, %0d results checked, %0d measured, %0d stray exits",
                 events_sent, reports_checked, status_tally[tllh_pkg::STAT_MEASURED],
                 status_tally[tllh_pkg::STAT_NO_START]);
        $display("tb: %0d starts, %0d out of range, %0d of 64 buckets hit, %0d mismatches",
                 status_tally[tllh_pkg::STAT_START], status_tally[tllh_pkg::STAT_RANGE],
                 buckets_used, error_count);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
